>>> hw/rtl/dedup_double_ended_work_queue_unit_macros.svh
// Assertion helpers used by the bound checker ddwq_checker.
`ifndef DEDUP_DOUBLE_ENDED_WORK_QUEUE_UNIT_MACROS_SVH
`define DEDUP_DOUBLE_ENDED_WORK_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDWQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DDWQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/ddwq_pkg.sv
`default_nettype none
package ddwq_pkg;

	// Queue geometry; DEPTH must be a power of two so the ring pointers wrap naturally.
	localparam int DEPTH    = 64;
	localparam int ID_WIDTH = 16;
	localparam int PTR_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);

	// Field widths on the stream ports
	localparam int CMD_W      = 3;
	localparam int ID_FIELD_W = 16;
	localparam int STAT_W     = 2;
	localparam int OUT_PACK_W = ID_FIELD_W + STAT_W + CNT_W;
	localparam int OUT_DATA_W = ((OUT_PACK_W + 7) / 8) * 8;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_UNIQ_BACK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_UNIQ_FRONT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BACK       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FRONT      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_POP        = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd5;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

endpackage
`default_nettype wire

>>> hw/rtl/dedup_double_ended_work_queue_unit.sv
// Channel   Dir  tdata                                   tuser
// s_axis    in   item_id[15:0]                           command[2:0]
// m_axis    out  popped_id[15:0] status[17:16]           popped_valid[0]
//                entry_count[24:18], zero above
//
// One command at a time. A unique push scans the queue through the single
// comparator, one stored entry per cycle. Plain pushes go through EXEC to OUT;
// pops go through POP_RD and POP_DONE for the registered RAM read; clear,
// pop on empty and unused codes go straight from IDLE to OUT.
// s_axis_tready is high only while idle; a stalled result parks the sequencer.
// Reset (arst_n, asynchronous) empties the queue; the entry RAM is not cleared.
`default_nettype none
module dedup_double_ended_work_queue_unit import ddwq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [ID_FIELD_W-1:0] s_axis_tdata,  // item_id
	input  logic [CMD_W-1:0]      s_axis_tuser,  // command
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // popped_id, status, entry_count
	output logic [0:0]            m_axis_tuser   // popped_valid
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SCAN     = 3'd1;
	localparam logic [2:0] ST_EXEC     = 3'd2;
	localparam logic [2:0] ST_POP_RD   = 3'd3;
	localparam logic [2:0] ST_POP_DONE = 3'd4;
	localparam logic [2:0] ST_OUT      = 3'd5;

	logic [2:0]            state_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [ID_WIDTH-1:0]   id_q;
	logic [PTR_W-1:0]      head_q;
	logic [CNT_W-1:0]      occ_q;
	logic [CNT_W-1:0]      issue_q;
	logic                  rd_pend_q;
	logic [ID_WIDTH-1:0]   rd_data_q;
	logic [ID_WIDTH-1:0]   res_popped_q;
	logic                  res_pvalid_q;
	logic [STAT_W-1:0]     res_status_q;
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic                  m_user_q;

	logic [ID_WIDTH-1:0]   mem [DEPTH];

	logic [PTR_W-1:0]      raddr;
	logic [PTR_W-1:0]      waddr;
	logic                  mem_we;
	logic                  is_front;
	logic                  is_full;
	logic                  out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// Decode push direction and fullness
	assign is_front = (cmd_q == CMD_UNIQ_FRONT) || (cmd_q == CMD_FRONT);
	assign is_full  = (occ_q == CNT_W'(DEPTH));
	assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	// Select the RAM addresses: scan walks from the head, pop reads the head
	always_comb begin
		raddr = head_q;
		if (state_q == ST_SCAN) begin
			raddr = head_q + issue_q[PTR_W-1:0];
		end
		waddr  = is_front ? (head_q - PTR_W'(1)) : (head_q + occ_q[PTR_W-1:0]);
		mem_we = (state_q == ST_EXEC) && !is_full;
	end

	// Entry RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= id_q;
		end
		rd_data_q <= mem[raddr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			occ_q        <= '0;
			issue_q      <= '0;
			rd_pend_q    <= 1'b0;
			cmd_q        <= CMD_UNIQ_BACK;
			id_q         <= '0;
			res_popped_q <= '0;
			res_pvalid_q <= 1'b0;
			res_status_q <= STAT_OK;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q        <= s_axis_tuser;
						id_q         <= s_axis_tdata[ID_WIDTH-1:0];
						issue_q      <= '0;
						rd_pend_q    <= 1'b0;
						res_popped_q <= '0;
						res_pvalid_q <= 1'b0;
						res_status_q <= STAT_OK;
						unique case (s_axis_tuser)
							CMD_UNIQ_BACK, CMD_UNIQ_FRONT: state_q <= ST_SCAN;
							CMD_BACK, CMD_FRONT:           state_q <= ST_EXEC;
							CMD_POP: begin
								if (occ_q == '0) begin
									res_status_q <= STAT_EMPTY;
									state_q      <= ST_OUT;
								end else begin
									state_q <= ST_POP_RD;
								end
							end
							CMD_CLEAR: begin
								head_q  <= '0;
								occ_q   <= '0;
								state_q <= ST_OUT;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_SCAN: begin
					// compare the entry read last cycle, issue the next read
					priority if (rd_pend_q && (rd_data_q == id_q)) begin
						res_status_q <= STAT_DUP;
						state_q      <= ST_OUT;
					end else if (issue_q < occ_q) begin
						issue_q   <= issue_q + CNT_W'(1);
						rd_pend_q <= 1'b1;
					end else if (!rd_pend_q) begin
						state_q <= ST_EXEC;
					end else begin
						rd_pend_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (is_full) begin
						res_status_q <= STAT_FULL;
					end else begin
						if (is_front) begin
							head_q <= head_q - PTR_W'(1);
						end
						occ_q <= occ_q + CNT_W'(1);
					end
					state_q <= ST_OUT;
				end
				ST_POP_RD: begin
					state_q <= ST_POP_DONE;
				end
				ST_POP_DONE: begin
					res_popped_q <= rd_data_q;
					res_pvalid_q <= 1'b1;
					head_q       <= head_q + PTR_W'(1);
					occ_q        <= occ_q - CNT_W'(1);
					state_q      <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register valid: set on load, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= OUT_DATA_W'({occ_q, res_status_q, ID_FIELD_W'(res_popped_q)});
			m_user_q <= res_pvalid_q;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/ddwq_checker.sv
`default_nettype none
`include "dedup_double_ended_work_queue_unit_macros.svh"
module ddwq_checker import ddwq_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic [ID_FIELD_W-1:0] s_axis_tdata,  // item_id
	input wire logic [CMD_W-1:0]      s_axis_tuser,  // command
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [OUT_DATA_W-1:0] m_axis_tdata,  // popped_id, status, entry_count
	input wire logic [0:0]            m_axis_tuser   // popped_valid
);

	logic [STAT_W-1:0] res_status;
	logic [CNT_W-1:0]  res_count;
	logic              in_xfer;

	assign res_status = m_axis_tdata[ID_FIELD_W +: STAT_W];
	assign res_count  = m_axis_tdata[ID_FIELD_W + STAT_W +: CNT_W];
	assign in_xfer    = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata)
		&& (s_axis_tuser == s_axis_tuser);

	// A stalled result holds
	`DDWQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	// Count never exceeds the queue depth
	`DDWQ_ASSERT_NOW(a_count_max, clk, arst_n, m_axis_tvalid, res_count <= CNT_W'(DEPTH), "entry count above depth")

	// A popped identifier always comes with status ok
	`DDWQ_ASSERT_NOW(a_pop_ok, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], res_status == STAT_OK, "popped item with bad status")

	// Pop on empty reports an empty queue
	`DDWQ_ASSERT_NOW(a_empty_cnt, clk, arst_n, m_axis_tvalid && (res_status == STAT_EMPTY), (res_count == '0) && !m_axis_tuser[0], "empty status with entries")

	// One command at a time: ready drops after a transfer
	`DDWQ_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_xfer, !s_axis_tready, "ready held after input transfer")

endmodule

bind dedup_double_ended_work_queue_unit ddwq_checker u_ddwq_checker (.*);
`default_nettype wire

>>> dv/work_queue_checker.sv
module work_queue_checker import ddwq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [ID_FIELD_W-1:0] s_axis_tdata,  // item_id
	input  logic [CMD_W-1:0]      s_axis_tuser,  // command
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,  // popped_id, status, entry_count
	input  logic [0:0]            m_axis_tuser,  // popped_valid
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct packed {
		logic [ID_FIELD_W-1:0] popped_id;
		logic                  popped_valid;
		logic [STAT_W-1:0]     status;
		logic [CNT_W-1:0]      entry_count;
	} queue_reply_t;

	// Shadow copy of the deque
	logic [ID_WIDTH-1:0] ring [DEPTH];
	logic [PTR_W-1:0]    front_ptr;
	logic [CNT_W-1:0]    queued;

	queue_reply_t pending_replies [$];
	int           fail_total;

	// Scan the occupied slots from the front for a matching identifier
	function automatic logic id_queued(input logic [ID_WIDTH-1:0] id);
		logic [PTR_W-1:0] slot;
		for (int k = 0; k < queued; k++) begin
			slot = front_ptr + PTR_W'(k);
			if (ring[slot] == id)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Duplicate check wins over the full check
	function automatic logic [STAT_W-1:0] insert_id(input logic [ID_WIDTH-1:0] id,
			input logic at_front, input logic unique_only);
		logic [PTR_W-1:0] tail;
		if (unique_only && id_queued(id))
			return STAT_DUP;
		if (queued == CNT_W'(DEPTH))
			return STAT_FULL;
		if (at_front) begin
			front_ptr = front_ptr - PTR_W'(1);
			ring[front_ptr] = id;
		end else begin
			tail = front_ptr + queued[PTR_W-1:0];
			ring[tail] = id;
		end
		queued = queued + CNT_W'(1);
		return STAT_OK;
	endfunction

	// Advance the shadow state by one command and return the reply it yields
	function automatic queue_reply_t apply_command(input logic [CMD_W-1:0] cmd,
			input logic [ID_FIELD_W-1:0] raw_id);
		queue_reply_t reply;
		logic [ID_WIDTH-1:0] id;
		reply = '0;
		id = raw_id[ID_WIDTH-1:0];
		case (cmd)
			CMD_UNIQ_BACK:  reply.status = insert_id(id, 1'b0, 1'b1);
			CMD_UNIQ_FRONT: reply.status = insert_id(id, 1'b1, 1'b1);
			CMD_BACK:       reply.status = insert_id(id, 1'b0, 1'b0);
			CMD_FRONT:      reply.status = insert_id(id, 1'b1, 1'b0);
			CMD_POP: begin
				if (queued == '0) begin
					reply.status = STAT_EMPTY;
				end else begin
					reply.popped_id    = ID_FIELD_W'(ring[front_ptr]);
					reply.popped_valid = 1'b1;
					front_ptr = front_ptr + PTR_W'(1);
					queued    = queued - CNT_W'(1);
				end
			end
			CMD_CLEAR: begin
				front_ptr = '0;
				queued    = '0;
			end
			default: ;
		endcase
		reply.entry_count = queued;
		return reply;
	endfunction

	// Compare each result transfer, then predict from each command transfer
	always @(posedge clk or negedge arst_n) begin
		queue_reply_t seen;
		queue_reply_t want;
		queue_reply_t fresh;
		if (!arst_n) begin
			front_ptr = '0;
			queued    = '0;
			pending_replies.delete();
			fail_total = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.popped_id    = m_axis_tdata[ID_FIELD_W-1:0];
				seen.status       = m_axis_tdata[ID_FIELD_W +: STAT_W];
				seen.entry_count  = m_axis_tdata[ID_FIELD_W+STAT_W +: CNT_W];
				seen.popped_valid = m_axis_tuser[0];
				if (pending_replies.size() == 0) begin
					fail_total++;
					$display("%0t: unexpected reply id=%h valid=%b status=%0d count=%0d",
						$time, seen.popped_id, seen.popped_valid, seen.status,
						seen.entry_count);
				end else begin
					want = pending_replies[0];
					pending_replies.delete(0);
					if (seen !== want) begin
						fail_total++;
						$display("%0t: expected id=%h valid=%b status=%0d count=%0d",
							$time, want.popped_id, want.popped_valid, want.status,
							want.entry_count);
						$display("%0t:   actual id=%h valid=%b status=%0d count=%0d",
							$time, seen.popped_id, seen.popped_valid, seen.status,
							seen.entry_count);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				fresh = apply_command(s_axis_tuser, s_axis_tdata);
				pending_replies.insert(pending_replies.size(), fresh);
			end
			mismatches  <= fail_total;
			outstanding <= pending_replies.size();
		end
	end

endmodule

>>> dv/tb_top.sv
module tb_top;
	import ddwq_pkg::*;

	// Codes the block ignores
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	localparam int TOTAL_ITEMS  = 1950;
	localparam int HOLD_AFTER   = 500;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int LIMIT_CYCLES = 1_200_000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [ID_FIELD_W-1:0] s_axis_tdata;  // item_id
	logic [CMD_W-1:0]      s_axis_tuser;  // command
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;  // popped_id, status, entry_count
	logic [0:0]            m_axis_tuser;  // popped_valid

	int          mismatches;
	int          outstanding;
	int          items_sent;
	logic        held_off;
	int unsigned cycle_count = 0;

	dedup_double_ended_work_queue_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	work_queue_checker queue_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Mostly no gap or a short one, now and then a long one
	function automatic int gap_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Hold one command until its transfer, then maybe idle
	task automatic offer(input logic [CMD_W-1:0] cmd, input logic [ID_FIELD_W-1:0] id);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= id;
		do @(posedge clk); while (!s_axis_tready);
		if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI)
			items_sent++;
		gap = gap_length();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Result side: ready stretches, random stalls, one long hold-off
	initial begin
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held_off && items_sent >= HOLD_AFTER) begin
				held_off = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			stall = gap_length();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Command side and verdict
	initial begin
		int                    seg;
		int                    n;
		int                    pick;
		logic                  use_pool;
		logic [ID_FIELD_W-1:0] id;
		logic [ID_FIELD_W-1:0] pool_base;
		items_sent    = 0;
		held_off      = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= CMD_POP;
		m_axis_tready <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pop, duplicates, both ends, ignored codes, clear
		offer(CMD_POP, 16'h0000);
		offer(CMD_UNIQ_BACK, 16'h0000);
		offer(CMD_UNIQ_FRONT, 16'hFFFF);
		offer(CMD_UNIQ_BACK, 16'h0000);
		offer(CMD_UNIQ_FRONT, 16'hFFFF);
		offer(CMD_BACK, 16'h0000);
		offer(CMD_FRONT, 16'h5A5A);
		offer(CMD_UNIQ_BACK, 16'hA5A5);
		offer(CMD_SPARE_LO, 16'h1111);
		offer(CMD_SPARE_HI, 16'hEEEE);
		offer(CMD_POP, 16'hFFFF);
		offer(CMD_POP, 16'h0000);
		offer(CMD_CLEAR, 16'hFFFF);
		offer(CMD_POP, 16'h0000);
		offer(CMD_FRONT, 16'h1234);
		offer(CMD_UNIQ_BACK, 16'h8000);
		offer(CMD_UNIQ_FRONT, 16'h8000);
		offer(CMD_POP, 16'h0000);
		offer(CMD_POP, 16'h0000);
		offer(CMD_POP, 16'h0000);

		// Random: fill past full, drain past empty, or mixed traffic
		while (items_sent < TOTAL_ITEMS) begin
			seg = $urandom_range(0, 9);
			if (seg < 2) begin
				n = $urandom_range(66, 80);
				for (int i = 0; i < n; i++) begin
					id = ID_FIELD_W'($urandom_range(0, 65535));
					offer(CMD_W'($urandom_range(CMD_UNIQ_BACK, CMD_FRONT)), id);
				end
				repeat (2) offer(CMD_UNIQ_FRONT, id);
				offer(CMD_UNIQ_BACK, id);
			end else if (seg < 4) begin
				n = $urandom_range(20, 80);
				repeat (n) offer(CMD_POP, ID_FIELD_W'($urandom_range(0, 65535)));
			end else begin
				n = $urandom_range(20, 60);
				use_pool = ($urandom_range(0, 9) < 7);
				pool_base = ID_FIELD_W'($urandom_range(0, 65535));
				for (int i = 0; i < n; i++) begin
					pick = $urandom_range(0, 99);
					id = use_pool ? pool_base ^ ID_FIELD_W'($urandom_range(0, 15))
						: ID_FIELD_W'($urandom_range(0, 65535));
					if (pick < 2)
						offer(CMD_CLEAR, id);
					else if (pick < 4)
						offer(pick[0] ? CMD_SPARE_HI : CMD_SPARE_LO, id);
					else if (pick < 40)
						offer(CMD_POP, id);
					else
						offer(CMD_W'($urandom_range(CMD_UNIQ_BACK, CMD_FRONT)), id);
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		// Let the count of the last transfer settle, drain, then allow a late stray result
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> dedup_double_ended_work_queue_unit.f
+incdir+hw/rtl
hw/rtl/ddwq_pkg.sv
hw/rtl/dedup_double_ended_work_queue_unit.sv
hw/rtl/ddwq_checker.sv
dv/work_queue_checker.sv
dv/tb_top.sv
